// ===== rtl/core/arl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range lookup package
// Field widths, command codes and the control and status groups shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package arl_pkg;

    localparam int ADDR_W              = 32;
    localparam int SLOT_W              = 12;
    localparam int COUNT_W             = 13;
    localparam int LAT_W               = 21;
    localparam int LON_W               = 22;
    localparam int DEFAULT_TABLE_DEPTH = 4096;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]       first;
        logic [ADDR_W-1:0]       last;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } arl_entry_t;

    typedef struct packed {
        logic start;
        logic load;
        logic step;
        logic emit;
    } arl_cmd_t;

    typedef struct packed {
        logic finish;
        logic out_free;
    } arl_stat_t;

endpackage

// ===== rtl/core/arl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range lookup controller
// Two-state sequencer that accepts words while idle and runs the search
// until the datapath reports a finished lookup and the output is free.
// ----------------------------------------------------------------------------
module arl_ctrl
    import arl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_command,
    output logic      s_ready,
    input  arl_stat_t stat,
    output arl_cmd_t  cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.start = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        cmd.emit  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_LOOKUP) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (stat.finish && stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/arl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range lookup datapath
// Range table memory, entry count register, search bounds, the range
// compare and the output register.
// ----------------------------------------------------------------------------
module arl_datapath
    import arl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [COUNT_W-1:0]      cfg_wr_data,
    input  arl_cmd_t                cmd,
    output arl_stat_t               stat,
    input  logic [SLOT_W-1:0]       s_slot,
    input  logic [ADDR_W-1:0]       s_range_first,
    input  logic [ADDR_W-1:0]       s_range_last,
    input  logic signed [LAT_W-1:0] s_entry_latitude,
    input  logic signed [LON_W-1:0] s_entry_longitude,
    input  logic [ADDR_W-1:0]       s_lookup_address,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_found,
    output logic [SLOT_W-1:0]       m_matched_slot,
    output logic signed [LAT_W-1:0] m_found_latitude,
    output logic signed [LON_W-1:0] m_found_longitude
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

    arl_entry_t mem [TABLE_DEPTH];
    arl_entry_t rd_entry_reg;
    arl_entry_t wr_entry;

    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] low_reg, low_next;
    logic [COUNT_W-1:0] high_reg, high_next;
    logic [COUNT_W-1:0] mid_reg, mid_next;
    logic [COUNT_W-1:0] count_clamped;
    logic [COUNT_W-1:0] step_low, step_high, step_mid;
    logic [EXT_W-1:0]   slot_ext, mid_ext;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic               slot_ok;
    logic               live, ge, le, hit, more;

    logic                    m_valid_reg, m_valid_next;
    logic                    found_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LON_W-1:0] lon_reg;

    assign count_clamped = (32'(count_reg) > 32'(TABLE_DEPTH)) ?
                           COUNT_W'(TABLE_DEPTH) : count_reg;

    assign live = (low_reg < high_reg);
    assign ge   = (rd_entry_reg.first <= addr_reg);
    assign le   = (addr_reg <= rd_entry_reg.last);
    assign hit  = live && ge && le;

    always_comb begin
        step_low  = low_reg;
        step_high = high_reg;
        if (ge) begin
            step_low = mid_reg + COUNT_W'(1);
        end else begin
            step_high = mid_reg;
        end
        step_mid = step_low + ((step_high - step_low) >> 1);
    end

    assign more = live && !hit && (step_low < step_high);

    assign stat.finish   = !more;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        mid_next  = mid_reg;
        if (cmd.start) begin
            low_next  = '0;
            high_next = count_clamped;
            mid_next  = count_clamped >> 1;
        end else if (cmd.step && more) begin
            low_next  = step_low;
            high_next = step_high;
            mid_next  = step_mid;
        end
    end

    assign slot_ext = EXT_W'(s_slot);
    assign wr_addr  = slot_ext[IDX_W-1:0];
    assign slot_ok  = (32'(s_slot) < 32'(TABLE_DEPTH));
    assign mid_ext  = EXT_W'(mid_next);
    assign rd_addr  = mid_ext[IDX_W-1:0];

    assign wr_entry.first = s_range_first;
    assign wr_entry.last  = s_range_last;
    assign wr_entry.lat   = s_entry_latitude;
    assign wr_entry.lon   = s_entry_longitude;

    always_ff @(posedge aclk) begin
        if (cmd.load && slot_ok) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        if (cmd.start) begin
            addr_reg <= s_lookup_address;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            found_reg <= hit;
            slot_reg  <= hit ? mid_reg[SLOT_W-1:0] : '0;
            lat_reg   <= hit ? rd_entry_reg.lat : '0;
            lon_reg   <= hit ? rd_entry_reg.lon : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = found_reg;
    assign m_matched_slot    = slot_reg;
    assign m_found_latitude  = lat_reg;
    assign m_found_longitude = lon_reg;

endmodule

// ===== rtl/core/address_range_table_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range table lookup
// Holds sorted address ranges with coordinates and binary-searches them.
//
//   Channel  Ports                     Direction  Word
//   input    s_valid / s_ready / s_*   in         load or lookup command
//   output   m_valid / m_ready / m_*   out        lookup result
//   config   cfg_wr_en / cfg_wr_data   in         entry count
//
// A load gives no result. A lookup starts with the accepted word and then
// runs its search steps, each of which waits for the registered table read
// of the entry it compares. Reset clears the entry count and the handshake
// state; the table holds no meaning until loaded. A result that waits for
// m_ready does not block the input; the next lookup holds in its final step
// until the output register is free, and no word is taken meanwhile.
// ----------------------------------------------------------------------------
module address_range_table_lookup
    import arl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [COUNT_W-1:0]      cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [SLOT_W-1:0]       s_slot,
    input  logic [ADDR_W-1:0]       s_range_first,
    input  logic [ADDR_W-1:0]       s_range_last,
    input  logic signed [LAT_W-1:0] s_entry_latitude,
    input  logic signed [LON_W-1:0] s_entry_longitude,
    input  logic [ADDR_W-1:0]       s_lookup_address,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_found,
    output logic [SLOT_W-1:0]       m_matched_slot,
    output logic signed [LAT_W-1:0] m_found_latitude,
    output logic signed [LON_W-1:0] m_found_longitude
);

    arl_cmd_t  cmd;
    arl_stat_t stat;

    arl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    arl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .stat              (stat),
        .s_slot            (s_slot),
        .s_range_first     (s_range_first),
        .s_range_last      (s_range_last),
        .s_entry_latitude  (s_entry_latitude),
        .s_entry_longitude (s_entry_longitude),
        .s_lookup_address  (s_lookup_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_matched_slot    (m_matched_slot),
        .m_found_latitude  (m_found_latitude),
        .m_found_longitude (m_found_longitude)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_LOOKUP) |=> !s_ready)
        else $error("lookup accepted but input stayed ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_LOAD) |=> s_ready)
        else $error("load word stalled the input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result issued while a search is still running");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |->
        (m_matched_slot == '0 && m_found_latitude == '0 && m_found_longitude == '0))
        else $error("miss result carries nonzero fields");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range table lookup testbench
// Loads sorted and deliberately unsorted range tables, sets the entry count
// from empty through the full table and past it, and looks up addresses
// inside, on the edges of and between the ranges. A scoreboard replays every
// accepted word on its own copy of the table and checks each lookup result
// in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import arl_pkg::*;

    typedef struct packed {
        logic                    command;
        logic [SLOT_W-1:0]       slot;
        logic [ADDR_W-1:0]       range_first;
        logic [ADDR_W-1:0]       range_last;
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
        logic [ADDR_W-1:0]       lookup_address;
    } request_t;

    typedef struct packed {
        logic                    found;
        logic [SLOT_W-1:0]       matched_slot;
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
    } answer_t;

    class range_lookup_scoreboard;
        logic [ADDR_W-1:0]       first_tab [DEFAULT_TABLE_DEPTH];
        logic [ADDR_W-1:0]       last_tab [DEFAULT_TABLE_DEPTH];
        logic signed [LAT_W-1:0] lat_tab [DEFAULT_TABLE_DEPTH];
        logic signed [LON_W-1:0] lon_tab [DEFAULT_TABLE_DEPTH];
        int                      entry_count;
        answer_t                 pending_answers [$];
        int                      errors;
        int                      lookups;
        int                      hits;
        int                      loads;

        function new();
            entry_count = 0;
            errors = 0;
            lookups = 0;
            hits = 0;
            loads = 0;
        endfunction

        function void set_count(int value);
            entry_count = value;
        endfunction

        function answer_t search_ranges(logic [ADDR_W-1:0] addr);
            int      lo;
            int      hi;
            int      mid;
            answer_t a;
            a = '0;
            lo = 0;
            hi = (entry_count > DEFAULT_TABLE_DEPTH) ? DEFAULT_TABLE_DEPTH : entry_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (first_tab[mid] <= addr) begin
                    if (addr <= last_tab[mid]) begin
                        a.found = 1'b1;
                        a.matched_slot = SLOT_W'(mid);
                        a.latitude = lat_tab[mid];
                        a.longitude = lon_tab[mid];
                        return a;
                    end
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return a;
        endfunction

        function void note_word(request_t w);
            answer_t a;
            if (w.command == CMD_LOAD) begin
                first_tab[w.slot] = w.range_first;
                last_tab[w.slot] = w.range_last;
                lat_tab[w.slot] = w.latitude;
                lon_tab[w.slot] = w.longitude;
                loads++;
            end else begin
                a = search_ranges(w.lookup_address);
                pending_answers.push_back(a);
                lookups++;
                if (a.found) begin
                    hits++;
                end
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $error("result word with no lookup waiting for it");
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found) begin
                $error("found expected %0d got %0d", want.found, got.found);
                errors++;
            end
            if (got.matched_slot !== want.matched_slot) begin
                $error("matched_slot expected %0d got %0d", want.matched_slot, got.matched_slot);
                errors++;
            end
            if (got.latitude !== want.latitude) begin
                $error("found_latitude expected %0d got %0d", want.latitude, got.latitude);
                errors++;
            end
            if (got.longitude !== want.longitude) begin
                $error("found_longitude expected %0d got %0d", want.longitude, got.longitude);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]      cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_command = CMD_LOAD;
    logic [SLOT_W-1:0]       s_slot = '0;
    logic [ADDR_W-1:0]       s_range_first = '0;
    logic [ADDR_W-1:0]       s_range_last = '0;
    logic signed [LAT_W-1:0] s_entry_latitude = '0;
    logic signed [LON_W-1:0] s_entry_longitude = '0;
    logic [ADDR_W-1:0]       s_lookup_address = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_found;
    logic [SLOT_W-1:0]       m_matched_slot;
    logic signed [LAT_W-1:0] m_found_latitude;
    logic signed [LON_W-1:0] m_found_longitude;

    range_lookup_scoreboard board;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_request = 0;
    int count_writes = 0;
    int tree_slots [$];

    address_range_table_lookup DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_slot            (s_slot),
        .s_range_first     (s_range_first),
        .s_range_last      (s_range_last),
        .s_entry_latitude  (s_entry_latitude),
        .s_entry_longitude (s_entry_longitude),
        .s_lookup_address  (s_lookup_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_matched_slot    (m_matched_slot),
        .m_found_latitude  (m_found_latitude),
        .m_found_longitude (m_found_longitude)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (rx_hold_request > 0) begin
                hold = rx_hold_request;
                rx_hold_request = 0;
                repeat (hold) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= aresetn && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Handshake signals only change at the rising edge, so their values at the
    // falling edge are the ones the next rising edge acts on.
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                board.check_answer({m_found, m_matched_slot, m_found_latitude,
                                    m_found_longitude});
            end
        end
    end

    function automatic logic signed [LAT_W-1:0] rand_latitude();
        case ($urandom_range(0, 9))
            0: return -LAT_W'(900000);
            1: return LAT_W'(900000);
            default: return LAT_W'(int'($urandom_range(0, 1800000)) - 900000);
        endcase
    endfunction

    function automatic logic signed [LON_W-1:0] rand_longitude();
        case ($urandom_range(0, 9))
            0: return -LON_W'(1800000);
            1: return LON_W'(1800000);
            default: return LON_W'(int'($urandom_range(0, 3600000)) - 1800000);
        endcase
    endfunction

    task automatic send_word(input request_t w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= w.command;
        s_slot <= w.slot;
        s_range_first <= w.range_first;
        s_range_last <= w.range_last;
        s_entry_latitude <= w.latitude;
        s_entry_longitude <= w.longitude;
        s_lookup_address <= w.lookup_address;
        @(negedge aclk);
        while (s_ready !== 1'b1) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        board.note_word(w);
    endtask

    task automatic load_slot(input int slot, input logic [ADDR_W-1:0] first,
                             input logic [ADDR_W-1:0] last,
                             input logic signed [LAT_W-1:0] lat,
                             input logic signed [LON_W-1:0] lon);
        request_t w;
        w.command = CMD_LOAD;
        w.slot = SLOT_W'(slot);
        w.range_first = first;
        w.range_last = last;
        w.latitude = lat;
        w.longitude = lon;
        w.lookup_address = $urandom;
        send_word(w);
    endtask

    task automatic look_up(input logic [ADDR_W-1:0] addr);
        request_t w;
        w.command = CMD_LOOKUP;
        w.slot = SLOT_W'($urandom);
        w.range_first = $urandom;
        w.range_last = $urandom;
        w.latitude = rand_latitude();
        w.longitude = rand_longitude();
        w.lookup_address = addr;
        send_word(w);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_count(input int value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_count(value);
        count_writes++;
    endtask

    // Sorted ranges with random gaps, one per equal share of the address space.
    task automatic fill_table(input int n);
        longint step;
        longint base;
        longint first;
        longint last;
        step = 64'd4294967296 / n;
        for (int i = 0; i < n; i++) begin
            base = i * step;
            first = base + $urandom_range(0, 32'(step / 4));
            last = first + $urandom_range(0, 32'(step / 2));
            load_slot(i, ADDR_W'(first), ADDR_W'(last), rand_latitude(), rand_longitude());
        end
    endtask

    // Loads only the slots that the search meets in its top levels and along
    // both outer edges of an n-slot sorted table. Hits on these slots never
    // lead the search through a slot that was left out.
    task automatic fill_search_tree(input int n, input int levels);
        int     lo_q [$];
        int     hi_q [$];
        int     lvl_q [$];
        int     lo;
        int     hi;
        int     lvl;
        int     mid;
        longint step;
        longint first;
        longint last;
        step = 64'd4294967296 / n;
        tree_slots.delete();
        lo_q.push_back(0);
        hi_q.push_back(n);
        lvl_q.push_back(0);
        while (lo_q.size() != 0) begin
            lo = lo_q.pop_front();
            hi = hi_q.pop_front();
            lvl = lvl_q.pop_front();
            if (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                first = mid * step + $urandom_range(0, 32'(step / 4));
                last = first + $urandom_range(0, 32'(step / 2));
                load_slot(mid, ADDR_W'(first), ADDR_W'(last), rand_latitude(),
                          rand_longitude());
                tree_slots.push_back(mid);
                if (lvl + 1 < levels || lo == 0 || hi == n) begin
                    lo_q.push_back(lo);
                    hi_q.push_back(mid);
                    lvl_q.push_back(lvl + 1);
                    lo_q.push_back(mid + 1);
                    hi_q.push_back(hi);
                    lvl_q.push_back(lvl + 1);
                end
            end
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(input int n);
        int                k;
        logic [ADDR_W-1:0] f;
        logic [ADDR_W-1:0] l;
        k = $urandom_range(0, n - 1);
        f = board.first_tab[k];
        l = board.last_tab[k];
        case ($urandom_range(0, 7))
            0, 1, 2: return (l >= f) ? f + $urandom_range(0, l - f) : f;
            3: return f;
            4: return l;
            5: return f - 1;
            6: return l + 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_hit_address(input int k);
        logic [ADDR_W-1:0] f;
        logic [ADDR_W-1:0] l;
        f = board.first_tab[k];
        l = board.last_tab[k];
        case ($urandom_range(0, 3))
            0: return f;
            1: return l;
            default: return f + $urandom_range(0, l - f);
        endcase
    endfunction

    task automatic random_traffic(input int n, input int items);
        int sel;
        int k;
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(0, 99);
            k = $urandom_range(0, n - 1);
            if (sel < 12) begin
                load_slot(k, board.first_tab[k], board.last_tab[k], rand_latitude(),
                          rand_longitude());
            end else if (sel < 16) begin
                load_slot($urandom_range(0, DEFAULT_TABLE_DEPTH - 1), $urandom, $urandom,
                          rand_latitude(), rand_longitude());
            end else begin
                look_up(pick_address(n));
            end
        end
    endtask

    task automatic tree_traffic(input int items);
        int k;
        for (int i = 0; i < items; i++) begin
            k = tree_slots[$urandom_range(0, tree_slots.size() - 1)];
            if ($urandom_range(0, 99) < 10) begin
                load_slot(k, board.first_tab[k], board.last_tab[k], rand_latitude(),
                          rand_longitude());
            end else begin
                look_up(pick_hit_address(k));
            end
        end
    endtask

    task automatic run_phase(input int n, input int tx, input int rx, input int items,
                             input int hold);
        write_count(n);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
        fill_table(n);
        rx_hold_request = hold;
        random_traffic(n, items);
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);
        load_slot(0, 32'h0000_0000, 32'hFFFF_FFFF, LAT_W'(900000), -LON_W'(1800000));
        load_slot(DEFAULT_TABLE_DEPTH - 1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, -LAT_W'(900000),
                  LON_W'(1800000));
        look_up(32'h1234_5678);
        write_count(1);
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);
        look_up(32'h1234_5678);
        load_slot(0, 32'd10, 32'd20, -LAT_W'(900000), LON_W'(1800000));
        load_slot(1, 32'd21, 32'hFFFF_FFFF, '0, '0);
        load_slot(2, 32'd0, 32'd5, LAT_W'(1), -LON_W'(1));
        write_count(3);
        look_up(32'd9);
        look_up(32'd10);
        look_up(32'd20);
        look_up(32'd21);
        look_up(32'hFFFF_FFFF);
        look_up(32'd3);
        look_up(32'd0);
        write_count(2);
        look_up(32'hFFFF_FFFF);
        look_up(32'd15);

        write_count(DEFAULT_TABLE_DEPTH);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fill_search_tree(DEFAULT_TABLE_DEPTH, 8);
        tree_traffic(120);
        write_count(8191);
        tree_traffic(80);
        run_phase(1, 63, 0, 100, 0);
        run_phase(37, 63, 0, 200, 0);
        run_phase(200, 0, 63, 250, 400);
        run_phase(2, 0, 63, 80, 0);
        run_phase(120, 30, 30, 150, 0);
        run_phase(13, 30, 30, 100, 0);
        wait_idle();

        $display("summary: %0d lookups (%0d hits), %0d loads, %0d entry count writes",
                 board.lookups, board.hits, board.loads, count_writes);
        $display("summary: counts 0 to 8191, four idling mixes, one long result hold-off");
        if (board.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/arl_pkg.sv
rtl/core/arl_ctrl.sv
rtl/core/arl_datapath.sv
rtl/core/address_range_table_lookup.sv
bench/tb.sv
